// ===== rtl/core/arh_pkg.sv =====
// arh_pkg: shared types and constants of the auto-ranging histogram
// depends on nothing; used by arh_seq and auto_ranging_histogram

package arh_pkg;

  localparam int unsigned SmpW     = 32;  // input sample width
  localparam int unsigned CntW     = 32;  // bin count width
  localparam int unsigned ExpW     = 5;   // scale exponent width
  localparam int unsigned IdxOutW  = 4;   // reported bin index width
  localparam int unsigned LowW     = 31;  // reported lower bound width
  localparam int unsigned OutDataW = IdxOutW + LowW + ExpW + CntW;

  localparam logic [ExpW-1:0] ExpMax = 5'd31;
  localparam logic [CntW-1:0] CntMax = '1;

  // command codes carried in tuser
  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdDump = 1'b1;

  // one reported bin
  typedef struct packed {
    logic [CntW-1:0]    bin_count;
    logic [ExpW-1:0]    width_exponent;
    logic [LowW-1:0]    bin_low;
    logic [IdxOutW-1:0] bin_index;
    logic               last_bin;
  } bin_rpt_t;

endpackage

// ===== rtl/core/arh_ram.sv =====
// arh_ram: generic single-port-write, single-port-read ram, registered read
// depends on nothing

module arh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/arh_seq.sv =====
// arh_seq: command sequencer of the histogram: add, bin fold passes, dump
// depends on arh_pkg; drives the count ram and holds per-bin valid bits

module arh_seq #(
  parameter int unsigned NumBins = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  logic [arh_pkg::SmpW-1:0]   in_sample_i,
  output logic                       rpt_valid_o,
  input  logic                       rpt_ready_i,
  output arh_pkg::bin_rpt_t          rpt_o,
  output logic                       ram_wr_en_o,
  output logic [$clog2(NumBins)-1:0] ram_wr_addr_o,
  output logic [arh_pkg::CntW-1:0]   ram_wr_data_o,
  output logic                       ram_rd_en_o,
  output logic [$clog2(NumBins)-1:0] ram_rd_addr_o,
  input  logic [arh_pkg::CntW-1:0]   ram_rd_data_i
);

  localparam int unsigned IW   = $clog2(NumBins);
  localparam int unsigned Half = (NumBins + 1) / 2;
  localparam logic [IW-1:0] LastIdx  = IW'(NumBins - 1);
  localparam logic [IW-1:0] LastPair = IW'(Half - 1);
  localparam logic [IW:0]   NumBinsX = (IW + 1)'(NumBins);
  localparam logic [arh_pkg::LowW-1:0] NumBinsW = arh_pkg::LowW'(NumBins);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SAddWr = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SFRdHi = 3'd3;
  localparam logic [2:0] SFWr   = 3'd4;
  localparam logic [2:0] SDump  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [arh_pkg::ExpW-1:0]      exp_q, exp_d;
  logic [arh_pkg::LowW-1:0]      sample_q, sample_d;
  logic [IW-1:0]                 idx_q, idx_d;
  logic [IW-1:0]                 k_q, k_d;
  logic [IW-1:0]                 dump_q, dump_d;
  logic [arh_pkg::CntW-1:0]      lo_q, lo_d;
  logic [NumBins-1:0]            valid_q, valid_d;
  logic                          rd_vld_q;

  logic [arh_pkg::LowW-1:0]      sel_smp;
  logic [arh_pkg::LowW-1:0]      shifted;
  logic                          fits;
  logic                          can_fold;
  logic [arh_pkg::CntW-1:0]      rd_cnt;
  logic [IW:0]                   hi_full;
  logic                          hi_exists;
  logic [IW:0]                   lo_next_full;
  logic [arh_pkg::CntW:0]        pair_sum;
  logic [arh_pkg::CntW-1:0]      pair_sat;
  logic [arh_pkg::CntW-1:0]      inc_sat;
  logic [IW+3:0]                 idx_ext;
  logic                          accept;

  assign accept  = in_valid_i && in_ready_o;
  assign sel_smp = (state_q == SIdle) ? in_sample_i[arh_pkg::LowW-1:0] : sample_q;
  assign shifted = sel_smp >> exp_q;
  assign fits    = shifted < NumBinsW;
  assign can_fold = !fits && (exp_q != arh_pkg::ExpMax);

  // entries never written since reset or since a fold cleared them read as zero
  assign rd_cnt = rd_vld_q ? ram_rd_data_i : '0;

  assign hi_full      = {k_q, 1'b1};
  assign hi_exists    = hi_full < NumBinsX;
  assign lo_next_full = {k_q, 1'b0} + (IW + 1)'(2);

  assign pair_sum = {1'b0, lo_q} + {1'b0, (hi_exists ? rd_cnt : '0)};
  assign pair_sat = pair_sum[arh_pkg::CntW] ? arh_pkg::CntMax : pair_sum[arh_pkg::CntW-1:0];
  assign inc_sat  = (rd_cnt == arh_pkg::CntMax) ? arh_pkg::CntMax
                                                : rd_cnt + arh_pkg::CntW'(1);

  assign in_ready_o  = (state_q == SIdle);
  assign rpt_valid_o = (state_q == SDump);

  assign idx_ext              = (IW + 4)'(dump_q);
  assign rpt_o.bin_index      = idx_ext[arh_pkg::IdxOutW-1:0];
  assign rpt_o.bin_low        = arh_pkg::LowW'(dump_q) << exp_q;
  assign rpt_o.width_exponent = exp_q;
  assign rpt_o.bin_count      = rd_cnt;
  assign rpt_o.last_bin       = (dump_q == LastIdx);

  always_comb begin
    state_d       = state_q;
    exp_d         = exp_q;
    sample_d      = sample_q;
    idx_d         = idx_q;
    k_d           = k_q;
    dump_d        = dump_q;
    lo_d          = lo_q;
    valid_d       = valid_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = idx_q;
    ram_wr_data_o = inc_sat;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = '0;

    unique case (state_q)
      SIdle, SCheck: begin
        if ((state_q == SCheck) || accept) begin
          if (state_q == SIdle) begin
            sample_d = in_sample_i[arh_pkg::LowW-1:0];
          end
          if ((state_q == SIdle) && (in_cmd_i == arh_pkg::CmdDump)) begin
            dump_d      = '0;
            ram_rd_en_o = 1'b1;
            state_d     = SDump;
          end else if ((state_q == SIdle) && in_sample_i[arh_pkg::SmpW-1]) begin
            state_d = SIdle;  // negative sample dropped
          end else if (can_fold) begin
            k_d         = '0;
            ram_rd_en_o = 1'b1;
            state_d     = SFRdHi;
          end else if (fits) begin
            idx_d         = shifted[IW-1:0];
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = shifted[IW-1:0];
            state_d       = SAddWr;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SAddWr: begin
        ram_wr_en_o    = 1'b1;
        valid_d[idx_q] = 1'b1;
        state_d        = SIdle;
      end
      SFRdHi: begin
        lo_d = rd_cnt;
        if (hi_exists) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = hi_full[IW-1:0];
        end
        state_d = SFWr;
      end
      SFWr: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = k_q;
        ram_wr_data_o = pair_sat;
        valid_d[k_q]  = 1'b1;
        if (k_q == LastPair) begin
          for (int unsigned j = Half; j < NumBins; j++) begin
            valid_d[j] = 1'b0;
          end
          exp_d   = exp_q + arh_pkg::ExpW'(1);
          state_d = SCheck;
        end else begin
          k_d           = k_q + IW'(1);
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = lo_next_full[IW-1:0];
          state_d       = SFRdHi;
        end
      end
      SDump: begin
        if (rpt_ready_i) begin
          if (dump_q == LastIdx) begin
            state_d = SIdle;
          end else begin
            dump_d        = dump_q + IW'(1);
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = dump_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      exp_q    <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      k_q      <= '0;
      dump_q   <= '0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      valid_q <= valid_d;
      k_q     <= k_d;
      dump_q  <= dump_d;
      idx_q   <= idx_d;
      if (ram_rd_en_o) begin
        rd_vld_q <= valid_q[ram_rd_addr_o];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    lo_q     <= lo_d;
  end

endmodule

// ===== rtl/core/auto_ranging_histogram.sv =====
// auto_ranging_histogram: top level of the auto-ranging histogram
// depends on arh_pkg, arh_ram and arh_seq
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid_i/tready_o    tuser: command, tdata: sample
//  m_axis    out  m_axis_tvalid_o/tready_i    tdata: bin report, tlast: last bin
//
// an add whose sample fits the current range reads the bin count, then writes
// back the incremented count through the count ram write port
// each range doubling runs one fold pass that merges each pair of bins into the lower half
// a dump reports every bin in order and waits while m_axis stalls
// reset clears the per-bin valid bits at once, so there is no clearing pass
// a negative sample is accepted and dropped

module auto_ranging_histogram #(
  parameter int unsigned NumBins = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [arh_pkg::SmpW-1:0]      s_axis_tdata_i,  // [31:0] sample
  input  logic                          s_axis_tuser_i,  // [0] command
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] bin_index, [34:4] bin_low, [39:35] width_exponent, [71:40] bin_count
  output logic [arh_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(NumBins);

  // count ram connections
  logic                     ram_wr_en;
  logic [IW-1:0]            ram_wr_addr;
  logic [arh_pkg::CntW-1:0] ram_wr_data;
  logic                     ram_rd_en;
  logic [IW-1:0]            ram_rd_addr;
  logic [arh_pkg::CntW-1:0] ram_rd_data;

  // bin report from the sequencer
  logic               rpt_valid;
  logic               rpt_ready;
  arh_pkg::bin_rpt_t  rpt;

  // output register
  logic               out_valid_q, out_valid_d;
  arh_pkg::bin_rpt_t  out_q;

  arh_ram #(
    .Width (arh_pkg::CntW),
    .Depth (NumBins)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  arh_seq #(
    .NumBins (NumBins)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_cmd_i      (s_axis_tuser_i),
    .in_sample_i   (s_axis_tdata_i),
    .rpt_valid_o   (rpt_valid),
    .rpt_ready_i   (rpt_ready),
    .rpt_o         (rpt),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  // the output register takes a new report when empty or being drained
  assign rpt_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rpt_ready) begin
      out_valid_d = rpt_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded on each report transaction
  always_ff @(posedge clk_i) begin
    if (rpt_valid && rpt_ready) begin
      out_q <= rpt;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.bin_count, out_q.width_exponent,
                            out_q.bin_low, out_q.bin_index};
  assign m_axis_tlast_o  = out_q.last_bin;

endmodule

// ===== bench/hist_sb_pkg.sv =====
`timescale 1ns / 1ps
// hist_sb_pkg: scoreboard class for the auto-ranging histogram bench
// depends on arh_pkg for the command codes and count limits

package hist_sb_pkg;
  import arh_pkg::*;

  localparam int unsigned NumBins = 16;

  // one bin report as seen on m_axis, tlast on top of tdata
  typedef struct packed {
    logic                 last;
    logic [CntW-1:0]      count;
    logic [ExpW-1:0]      width_exp;
    logic [LowW-1:0]      low;
    logic [IdxOutW-1:0]   index;
  } report_t;

  class hist_scoreboard;
    logic [CntW-1:0] counts [NumBins];
    logic [ExpW-1:0] scale_exp;
    report_t         dump_q [$];
    int unsigned     fails;

    function new();
      foreach (counts[i]) counts[i] = '0;
      scale_exp = '0;
      fails = 0;
    endfunction

    // one doubling of the bin width: pairs fold into the lower half
    function void fold_pairs();
      logic [CntW-1:0] merged [NumBins];
      logic [CntW:0]   sum;
      foreach (merged[i]) merged[i] = '0;
      for (int k = 0; 2 * k < NumBins; k++) begin
        sum = {1'b0, counts[2*k]};
        if (2 * k + 1 < NumBins) sum = sum + {1'b0, counts[2*k+1]};
        merged[k] = sum[CntW] ? CntMax : sum[CntW-1:0];
      end
      counts = merged;
    endfunction

    // update the histogram for an accepted transaction, queue reports of a dump
    function void note_input(logic cmd, logic [SmpW-1:0] smp);
      logic [63:0] idx;
      report_t     rpt;
      if (cmd == CmdAdd) begin
        if (smp[SmpW-1]) return;
        while (scale_exp < ExpMax && {32'b0, smp} >= (64'(NumBins) << scale_exp)) begin
          scale_exp++;
          fold_pairs();
        end
        idx = {32'b0, smp} >> scale_exp;
        if (idx < NumBins && counts[idx] != CntMax) counts[idx] = counts[idx] + 1'b1;
        return;
      end
      for (int i = 0; i < NumBins; i++) begin
        rpt.index     = IdxOutW'(i);
        rpt.low       = LowW'(64'(i) << scale_exp);
        rpt.width_exp = scale_exp;
        rpt.count     = counts[i];
        rpt.last      = (i == NumBins - 1);
        dump_q.push_back(rpt);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                 $time, name, want, want, got, got);
        fails++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (dump_q.size() == 0) begin
        $display("%0t: bin report with none expected, got 0x%h", $time, got);
        fails++;
        return;
      end
      want = dump_q.pop_front();
      compare_field("bin_index", 32'(want.index), 32'(got.index));
      compare_field("bin_low", 32'(want.low), 32'(got.low));
      compare_field("width_exponent", 32'(want.width_exp), 32'(got.width_exp));
      compare_field("bin_count", want.count, got.count);
      compare_field("last_bin", 32'(want.last), 32'(got.last));
    endfunction

    function int unsigned pending();
      return dump_q.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for auto_ranging_histogram
// depends on arh_pkg, hist_sb_pkg and the histogram rtl

module tb_top;
  import arh_pkg::*;
  import hist_sb_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 600;  // room for a run of fold passes
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned NumPhases   = 4;

  logic                clk;
  logic                rst_n;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SmpW-1:0]     s_axis_tdata;   // [31:0] sample
  logic                s_axis_tuser;   // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [3:0] bin_index, [34:4] bin_low, [39:35] width_exponent, [71:40] bin_count
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  hist_scoreboard sb;
  int unsigned    cycle_cnt = 0;
  int unsigned    src_idle_pct = 0;   // sender gap odds per cycle
  int unsigned    sink_stall_pct = 0; // receiver stall odds per cycle

  auto_ranging_histogram #(
    .NumBins(NumBins)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls on m_axis
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // every accepted bin report goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_report({m_axis_tlast, m_axis_tdata});
  end

  // present one transaction, with random gaps ahead of it, and wait for acceptance
  task automatic drive_request(input logic cmd, input logic [SmpW-1:0] smp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= smp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(cmd, smp);
  endtask

  // sender holds off until every queued bin report has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // random mix; sample magnitude grows with n so folds keep happening through the run
  function automatic logic [SmpW:0] pick_item(int unsigned n, int unsigned phase);
    int unsigned roll;
    int unsigned bits;
    logic [SmpW-1:0] smp;
    roll = $urandom_range(0, 99);
    bits = 4 + (n * 27) / (PhaseItems * NumPhases) + $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) bits = bits - $urandom_range(0, 3);
    if (bits > 31) bits = 31;
    if (roll < 8) return {CmdDump, $urandom()};
    if (roll < 16) return {CmdAdd, 1'b1, 31'($urandom())};  // negative, dropped
    if (phase == NumPhases - 1 && roll < 19) begin
      // full positive range, including the largest sample
      smp = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : {1'b0, 31'($urandom())};
      return {CmdAdd, smp};
    end
    smp = $urandom() & ((32'h1 << bits) - 1);
    return {CmdAdd, smp};
  endfunction

  initial begin : stimulus
    logic [SmpW:0] item;
    int unsigned   n;
    sb = new();
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdAdd;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dump, bin edges, both negative extremes, single and multiple folds
    drive_request(CmdDump, 32'hDEAD_BEEF);
    drive_request(CmdAdd, 32'd0);
    drive_request(CmdAdd, 32'd15);
    drive_request(CmdAdd, 32'd15);
    drive_request(CmdAdd, 32'hFFFF_FFFF);  // -1 is dropped
    drive_request(CmdAdd, 32'h8000_0000);  // most negative is dropped
    drive_request(CmdDump, 32'd0);
    drive_request(CmdAdd, 32'd16);         // first doubling
    drive_request(CmdAdd, 32'd31);
    drive_request(CmdAdd, 32'd32);         // second doubling
    drive_request(CmdAdd, 32'd1);
    drive_request(CmdDump, 32'hFFFF_FFFF);
    drive_request(CmdAdd, 32'd100);        // third doubling
    drive_request(CmdAdd, 32'd127);        // top bin, just inside the range
    drive_request(CmdAdd, 32'd0);
    drive_request(CmdAdd, 32'd600);        // several doublings in one go
    drive_request(CmdDump, 32'd0);
    hold_until_drained();

    // random phases: no idling, sender gaps, receiver stalls, both
    n = 0;
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        item = pick_item(n, phase);
        drive_request(item[SmpW], item[SmpW-1:0]);
        n++;
      end
      // close each phase with a dump and let it drain completely
      drive_request(CmdDump, $urandom());
      hold_until_drained();
    end

    // watch for stray reports while any fold pass finishes
    repeat (DrainCycles) @(posedge clk);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
